// ----- design/lsw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lsw_pkg
// Shared types, constants and the segment pattern ROM for the LCD segment
// character writer.
// ----------------------------------------------------------------------------
package lsw_pkg;

  localparam int NUM_DISPLAY_REGS = 20;
  localparam int NUM_DIGITS_DEF   = 6;
  localparam int WRITES_PER_CHAR  = 4;
  localparam int GROUP_STRIDE     = NUM_DISPLAY_REGS / WRITES_PER_CHAR;
  localparam int REG_IDX_W        = 5;
  localparam int CMD_Q_DEPTH      = 2;
  localparam int CMD_Q_PTR_W      = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
  localparam int CMD_Q_CNT_W      = $clog2(CMD_Q_DEPTH + 1);

  localparam logic [7:0] CHAR_FIRST    = 8'h2A;
  localparam logic [7:0] CHAR_LAST     = 8'h7A;
  localparam logic [7:0] LOWER_FIRST   = 8'h61;
  localparam logic [7:0] CASE_BIT_MASK = 8'h20;
  localparam logic [7:0] NIB_LO_MASK   = 8'h0F;
  localparam logic [7:0] NIB_HI_MASK   = 8'hF0;

  localparam logic [REG_IDX_W-1:0] LAST_REG_IDX = REG_IDX_W'(NUM_DISPLAY_REGS - 1);

  // Command handed from front to back.
  typedef struct packed {
    logic        clear;
    logic        odd;
    logic [1:0]  base;
    logic [15:0] seg;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_WRITE
  } bk_state_t;

  // Segment pattern by code - '*'. Past the table (backquote) reads blank.
  function automatic logic [15:0] seg_rom(input logic [5:0] code);
    logic [15:0] p;
    unique case (code)
      6'd0:  p = 16'h0A51;  6'd1:  p = 16'h2A80;  6'd2:  p = 16'h0000;
      6'd3:  p = 16'h0A00;  6'd4:  p = 16'h0A51;  6'd5:  p = 16'h0000;
      6'd6:  p = 16'h5559;  6'd7:  p = 16'h0118;  6'd8:  p = 16'h1E11;
      6'd9:  p = 16'h1B11;  6'd10: p = 16'h0B50;  6'd11: p = 16'h1B41;
      6'd12: p = 16'h1F41;  6'd13: p = 16'h0111;  6'd14: p = 16'h1F51;
      6'd15: p = 16'h1B51;  6'd23: p = 16'h0F51;  6'd24: p = 16'h3991;
      6'd25: p = 16'h1441;  6'd26: p = 16'h3191;  6'd27: p = 16'h1E41;
      6'd28: p = 16'h0E41;  6'd29: p = 16'h1D41;  6'd30: p = 16'h0F50;
      6'd31: p = 16'h2080;  6'd32: p = 16'h1510;  6'd33: p = 16'h8648;
      6'd34: p = 16'h1440;  6'd35: p = 16'h0578;  6'd36: p = 16'h8570;
      6'd37: p = 16'h1551;  6'd38: p = 16'h0E51;  6'd39: p = 16'h9551;
      6'd40: p = 16'h8E51;  6'd41: p = 16'h9021;  6'd42: p = 16'h2081;
      6'd43: p = 16'h1550;  6'd44: p = 16'h4448;  6'd45: p = 16'hC550;
      6'd46: p = 16'hC028;  6'd47: p = 16'h2028;  6'd48: p = 16'h5009;
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ----- design/lcd_segment_char_writer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_segment_char_writer
// Fourteen-segment character writer with a 20-byte display memory image.
// ----------------------------------------------------------------------------
// Usage: push a transaction with kind=0 to show an ASCII character ('*'..'z',
// lowercase shown as uppercase) at digit position 0..NUM_DIGITS-1, or kind=1
// to blank the display. A character produces four register writes (registers
// pos/2, +5, +10, +15) and a clear produces twenty writes (0 up to 19), each
// carrying the new full byte; out_last marks the final write of a request.
// Characters out of range and positions at or above NUM_DIGITS are taken and
// produce nothing. The image is all zero after reset. The back-end sequencer
// issues one write per cycle when not stalled at its output register, with
// back-to-back commands chained without a gap; a 2-deep command queue lets
// new requests be taken while the sequencer is busy.
// ----------------------------------------------------------------------------
module lcd_segment_char_writer import lsw_pkg::*; #(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request side
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  in_kind,
  input  wire logic [2:0]            in_position,
  input  wire logic [7:0]            in_character,
  // register write side
  output logic                       empty,
  input  wire logic                  pop,
  output logic [REG_IDX_W-1:0]       out_reg_index,
  output logic [7:0]                 out_reg_value,
  output logic                       out_last
);

  logic q_push;
  cmd_t q_wr_cmd;
  cmd_t q_rd_cmd;
  logic q_pop;
  logic q_full;
  logic q_empty;

  // Front: accept and classify; drops no-op requests.
  lsw_front #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_front (
    .push         (push),
    .q_full       (q_full),
    .in_kind      (in_kind),
    .in_position  (in_position),
    .in_character (in_character),
    .full         (full),
    .q_push       (q_push),
    .q_cmd        (q_wr_cmd)
  );

  // Command queue decoupling front and back.
  lsw_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_cmd  (q_wr_cmd),
    .rd_en   (q_pop),
    .rd_cmd  (q_rd_cmd),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // Back: read-modify-write sequencer holding the display image.
  lsw_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_cmd         (q_rd_cmd),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .out_reg_index (out_reg_index),
    .out_reg_value (out_reg_value),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire

// ----- design/lsw_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lsw_front
// Accepts input transactions, drops ones that write nothing, and turns the
// rest into clear or character commands with the segment pattern resolved.
// ----------------------------------------------------------------------------
module lsw_front import lsw_pkg::*; #(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  wire logic       push,
  input  wire logic       q_full,
  input  wire logic       in_kind,
  input  wire logic [2:0] in_position,
  input  wire logic [7:0] in_character,
  output logic            full,
  output logic            q_push,
  output cmd_t            q_cmd
);

  localparam logic [2:0] POS_LIMIT = 3'(NUM_DIGITS);

  logic       accept;
  logic       char_ok;
  logic [7:0] folded;
  logic [5:0] code;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    folded = (in_character >= LOWER_FIRST) ? (in_character & ~CASE_BIT_MASK)
                                           : in_character;
    code    = 6'(folded - CHAR_FIRST);
    char_ok = (in_position < POS_LIMIT) &&
              (in_character >= CHAR_FIRST) && (in_character <= CHAR_LAST);
  end

  always_comb begin
    q_cmd.clear = in_kind;
    q_cmd.odd   = in_position[0];
    q_cmd.base  = in_position[2:1];
    q_cmd.seg   = seg_rom(code);
    q_push      = accept && (in_kind || char_ok);
  end

endmodule
`default_nettype wire

// ----- design/lsw_cmd_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lsw_cmd_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module lsw_cmd_fifo import lsw_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire cmd_t wr_cmd,
  input  wire logic rd_en,
  output cmd_t      rd_cmd,
  output logic      q_full,
  output logic      q_empty
);

  cmd_t                   mem_r [CMD_Q_DEPTH];
  logic [CMD_Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_Q_CNT_W-1:0] count_r, count_nxt;
  logic                   do_wr, do_rd;

  assign q_full  = (count_r == CMD_Q_CNT_W'(CMD_Q_DEPTH));
  assign q_empty = (count_r == '0);
  assign rd_cmd  = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == CMD_Q_PTR_W'(CMD_Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == CMD_Q_PTR_W'(CMD_Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule
`default_nettype wire

// ----- design/lsw_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lsw_back
// Executes commands against the display image: one register write per cycle
// unless stalled at the single output register through which writes are presented.
// ----------------------------------------------------------------------------
module lsw_back import lsw_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_empty,
  input  wire cmd_t                  q_cmd,
  output logic                       q_pop,
  input  wire logic                  pop,
  output logic                       empty,
  output logic [REG_IDX_W-1:0]       out_reg_index,
  output logic [7:0]                 out_reg_value,
  output logic                       out_last
);

  bk_state_t            state_r, state_nxt;
  cmd_t                 cmd_r;
  logic [REG_IDX_W-1:0] step_r, step_nxt;
  logic [7:0]           image_r [NUM_DISPLAY_REGS];

  logic                 out_valid_r;
  logic [REG_IDX_W-1:0] out_idx_r;
  logic [7:0]           out_val_r;
  logic                 out_last_r;

  logic                 can_emit;
  logic                 emit_en;
  logic [REG_IDX_W-1:0] emit_idx;
  logic [7:0]           emit_val;
  logic                 emit_last;
  logic [3:0]           nib;
  logic [7:0]           old_val;

  assign can_emit = !out_valid_r || pop;

  // Outputs of the sequencer.
  always_comb begin
    emit_en   = 1'b0;
    emit_idx  = step_r;
    emit_val  = '0;
    emit_last = 1'b0;
    nib       = '0;
    old_val   = '0;
    q_pop     = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        q_pop = !q_empty;
      end
      BK_CLEAR: begin
        emit_en   = can_emit;
        emit_idx  = step_r;
        emit_last = (step_r == LAST_REG_IDX);
      end
      BK_WRITE: begin
        emit_en   = can_emit;
        emit_idx  = REG_IDX_W'(cmd_r.base) +
                    REG_IDX_W'(step_r[1:0]) * REG_IDX_W'(GROUP_STRIDE);
        nib       = cmd_r.seg[{step_r[1:0], 2'b00} +: 4];
        old_val   = image_r[emit_idx];
        emit_val  = cmd_r.odd ? ((old_val & NIB_LO_MASK) | {nib, 4'h0})
                              : ((old_val & NIB_HI_MASK) | {4'h0, nib});
        emit_last = (step_r[1:0] == 2'(WRITES_PER_CHAR - 1));
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
    if (emit_en && emit_last) begin
      q_pop = !q_empty;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_cmd.clear ? BK_CLEAR : BK_WRITE;
        end
      end
      BK_CLEAR, BK_WRITE: begin
        if (emit_en && emit_last) begin
          if (!q_empty) begin
            state_nxt = q_cmd.clear ? BK_CLEAR : BK_WRITE;
          end else begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (q_pop) begin
      step_nxt = '0;
    end else if (emit_en) begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_DISPLAY_REGS; i++) begin
        image_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (emit_en) begin
        out_valid_r       <= 1'b1;
        image_r[emit_idx] <= emit_val;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if (emit_en) begin
      out_idx_r  <= emit_idx;
      out_val_r  <= emit_val;
      out_last_r <= emit_last;
    end
  end

  assign empty         = !out_valid_r;
  assign out_reg_index = out_idx_r;
  assign out_reg_value = out_val_r;
  assign out_last      = out_last_r;

endmodule
`default_nettype wire
